// File: rtl/core/keyword_substitution_cipher_unit_assert.svh
// Assertion macros for the keyword substitution cipher unit.
// Included by the top level; depends on nothing else.
`ifndef KEYWORD_SUBSTITUTION_CIPHER_UNIT_ASSERT_SVH
`define KEYWORD_SUBSTITUTION_CIPHER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KSC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ksc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define KSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ksc assertion failed");

`endif

// File: rtl/core/ksc_pkg.sv
// Shared constants, types and helper functions for the keyword substitution cipher unit.
// Used by the controller, the datapath and the top level; depends on nothing.
package ksc_pkg;

    localparam int LETTERS   = 26;
    localparam int IDX_W     = 5;
    localparam int COUNT_SAT = 27;

    localparam logic [7:0]       CHAR_A      = 8'h41;
    localparam logic [IDX_W-1:0] LAST_LETTER = IDX_W'(LETTERS - 1);

    localparam logic FUNC_KEY  = 1'b0;
    localparam logic FUNC_TEXT = 1'b1;

    typedef struct packed {
        logic key_take;
        logic text_take;
        logic build_start;
        logic place_key;
        logic place_rest;
    } ksc_cmd_t;

    typedef struct packed {
        logic key_done;
        logic rest_done;
    } ksc_stat_t;

    function automatic logic is_letter(input logic [7:0] b);
        is_letter = ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
    endfunction

    // Upper and lower case letters share the low five bits, 1 for A through 26 for Z.
    function automatic logic [IDX_W-1:0] letter_idx(input logic [7:0] b);
        letter_idx = is_letter(b) ? (b[IDX_W-1:0] - IDX_W'(1)) : '0;
    endfunction

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] x);
        wrap_inc = (x == LAST_LETTER) ? '0 : (x + IDX_W'(1));
    endfunction

endpackage

// File: rtl/core/keyword_substitution_cipher_unit.sv
// Keyword substitution cipher unit. A text byte is encoded into the output register; text
// bytes stream one per cycle while the output is taken. The final key byte starts a table
// build that holds off input; the build writes the table through its single write port.
// Reset sets the table to the identity mapping, closes any open key and empties the output
// register.
module keyword_substitution_cipher_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       func,
    input  logic [7:0] char_in,
    input  logic       key_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] char_out
);

    `include "keyword_substitution_cipher_unit_assert.svh"

    ksc_pkg::ksc_cmd_t  cmd;
    ksc_pkg::ksc_stat_t stat;

    ksc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .key_last  (key_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    ksc_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .char_in  (char_in),
        .key_last (key_last),
        .char_out (char_out),
        .cmd      (cmd),
        .stat     (stat)
    );

    // A held result blocks new input so no transaction result is overwritten.
    `KSC_ASSERT_SAME(a_no_accept_when_full, clk, rst_n, out_valid && !out_ready, !in_ready)
    // The final key byte starts the build, which holds off input.
    `KSC_ASSERT_NEXT(a_build_blocks, clk, rst_n, in_valid && in_ready && !func && key_last, !in_ready)
    // A key byte produces no result.
    `KSC_ASSERT_NEXT(a_key_no_result, clk, rst_n, in_valid && in_ready && !func && !out_valid, !out_valid)
    // A text byte always produces a result.
    `KSC_ASSERT_NEXT(a_text_result, clk, rst_n, in_valid && in_ready && func, out_valid)

endmodule

// File: rtl/core/ksc_ctrl.sv
// Controller of the keyword substitution cipher unit: handshakes and table build sequencing.
// Depends on ksc_pkg for the command and status types.
module ksc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               func,
    input  logic               key_last,
    output logic               out_valid,
    input  logic               out_ready,
    output ksc_pkg::ksc_cmd_t  cmd,
    input  ksc_pkg::ksc_stat_t stat
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PLACE_KEY,
        ST_PLACE_REST
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   in_accept;

    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign in_accept = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.key_take    = in_accept && (func == ksc_pkg::FUNC_KEY);
        cmd.text_take   = in_accept && (func == ksc_pkg::FUNC_TEXT);
        cmd.build_start = cmd.key_take && key_last;
        cmd.place_key   = (state_reg == ST_PLACE_KEY);
        cmd.place_rest  = (state_reg == ST_PLACE_REST);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.build_start)
                    state_next = ST_PLACE_KEY;
            end
            ST_PLACE_KEY:
            begin
                if (stat.key_done)
                    state_next = ST_PLACE_REST;
            end
            ST_PLACE_REST:
            begin
                if (stat.rest_done)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.text_take)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/core/ksc_datapath.sv
// Datapath of the keyword substitution cipher unit: key collection, table and encoder.
// Depends on ksc_pkg; driven by ksc_ctrl through command and status structs.
module ksc_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         char_in,
    input  logic               key_last,
    output logic [7:0]         char_out,
    input  ksc_pkg::ksc_cmd_t  cmd,
    output ksc_pkg::ksc_stat_t stat
);

    localparam int W = ksc_pkg::IDX_W;
    localparam int N = ksc_pkg::LETTERS;

    logic [W-1:0] ctab_reg [N];
    logic [W-1:0] uniq_reg [N];

    logic [N-1:0] used_mask_reg, used_mask_next;
    logic [W-1:0] ucnt_reg, ucnt_next;
    logic [W-1:0] kcnt_reg, kcnt_next;
    logic         key_open_reg, key_open_next;
    logic [W-1:0] last_reg, last_next;
    logic [W-1:0] pos_reg, pos_next;
    logic [W-1:0] idx_reg, idx_next;
    logic [W-1:0] c_reg, c_next;
    logic [7:0]   char_out_reg, char_out_next;

    logic         lok;
    logic [W-1:0] li;
    logic [N-1:0] mask_eff;
    logic [W-1:0] ucnt_eff;
    logic [W-1:0] kcnt_eff;
    logic         add;
    logic [W-1:0] c_step;
    logic         wr_en;
    logic [W-1:0] wr_addr;
    logic [W-1:0] wr_data;

    assign lok = ksc_pkg::is_letter(char_in);
    assign li  = ksc_pkg::letter_idx(char_in);

    // A key byte that opens a new key sees the collection state as cleared.
    assign mask_eff = key_open_reg ? used_mask_reg : '0;
    assign ucnt_eff = key_open_reg ? ucnt_reg : '0;
    assign kcnt_eff = key_open_reg ? kcnt_reg : '0;
    assign add      = lok && !mask_eff[li] && (ucnt_eff < W'(N));
    assign c_step   = ksc_pkg::wrap_inc(c_reg);

    assign stat.key_done  = (idx_reg == ucnt_reg);
    assign stat.rest_done = (idx_reg == ksc_pkg::LAST_LETTER);
    assign char_out       = char_out_reg;

    always_comb
    begin
        used_mask_next = used_mask_reg;
        ucnt_next      = ucnt_reg;
        kcnt_next      = kcnt_reg;
        key_open_next  = key_open_reg;
        last_next      = last_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        c_next         = c_reg;
        char_out_next  = char_out_reg;
        wr_en          = 1'b0;
        wr_addr        = pos_reg;
        wr_data        = uniq_reg[idx_reg];

        if (cmd.key_take)
        begin
            used_mask_next = add ? (mask_eff | (N'(1) << li)) : mask_eff;
            ucnt_next      = ucnt_eff + W'(add);
            kcnt_next      = (kcnt_eff < W'(ksc_pkg::COUNT_SAT)) ? (kcnt_eff + W'(1)) : kcnt_eff;
            key_open_next  = !key_last;
            last_next      = add ? li : last_reg;
        end

        if (cmd.build_start)
        begin
            // Placement starts at count minus one, or at zero for a long key.
            if ((kcnt_next == '0) || (kcnt_next > W'(N)))
                pos_next = '0;
            else
                pos_next = kcnt_next - W'(1);
            idx_next = '0;
            c_next   = (ucnt_next != '0) ? last_next : ksc_pkg::LAST_LETTER;
        end

        if (cmd.text_take)
            char_out_next = lok ? (ksc_pkg::CHAR_A + {3'b000, ctab_reg[li]}) : char_in;

        if (cmd.place_key)
        begin
            if (stat.key_done)
                idx_next = '0;
            else
            begin
                wr_en    = 1'b1;
                pos_next = ksc_pkg::wrap_inc(pos_reg);
                idx_next = idx_reg + W'(1);
            end
        end

        if (cmd.place_rest)
        begin
            c_next   = c_step;
            idx_next = idx_reg + W'(1);
            wr_data  = c_step;
            if (!used_mask_reg[c_step])
            begin
                wr_en    = 1'b1;
                pos_next = ksc_pkg::wrap_inc(pos_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
                ctab_reg[i] <= W'(i);
            used_mask_reg <= '0;
            ucnt_reg      <= '0;
            kcnt_reg      <= '0;
            key_open_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
                ctab_reg[wr_addr] <= wr_data;
            used_mask_reg <= used_mask_next;
            ucnt_reg      <= ucnt_next;
            kcnt_reg      <= kcnt_next;
            key_open_reg  <= key_open_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.key_take && add)
            uniq_reg[ucnt_eff] <= li;
        last_reg     <= last_next;
        pos_reg      <= pos_next;
        idx_reg      <= idx_next;
        c_reg        <= c_next;
        char_out_reg <= char_out_next;
    end

endmodule
